FILE: src/thermal_q_learning_gear_governor_assert.svh
// Assertion macros for the thermal gear governor.
`ifndef THERMAL_Q_LEARNING_GEAR_GOVERNOR_ASSERT_SVH
`define THERMAL_Q_LEARNING_GEAR_GOVERNOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define TQG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TQG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TQG_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TQG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: src/tqg_pkg.sv
package tqg_pkg;
  localparam int NumStates    = 100;
  localparam int HistDepth    = 10;
  localparam int TableDepth   = NumStates * 4;
  localparam int TableAw      = $clog2(TableDepth);
  localparam int StateW       = $clog2(NumStates);
  localparam int HistW        = $clog2(HistDepth + 1);

  localparam logic [2:0] RegLearn = 3'd0;
  localparam logic [2:0] RegDisc  = 3'd1;
  localparam logic [2:0] RegHot   = 3'd2;
  localparam logic [2:0] RegWarm  = 3'd3;
  localparam logic [2:0] RegCool  = 3'd4;
  localparam logic [2:0] RegHold  = 3'd5;

  localparam logic signed [31:0] PenHot   = 32'sd13107200;
  localparam logic signed [31:0] PenWarmT = 32'sd3932160;
  localparam logic signed [31:0] PenWarm3 = 32'sd655360;
  localparam logic signed [31:0] PenCool  = 32'sd2621440;
  localparam logic signed [31:0] PenSlow  = 32'sd3276800;
  localparam logic signed [31:0] PenShift = 32'sd983040;

  // Work factor per unit of load: MHz / 25 * 128 when the gear holds,
  // MHz / 100 * 2176 after a shift (still to be divided by five).
  function automatic logic [15:0] gear_work(input logic [2:0] g, input logic shifted);
    logic [15:0] f;
    unique case (g)
      3'd1: f = shifted ? 16'd17408 : 16'd4096;
      3'd2: f = shifted ? 16'd32640 : 16'd7680;
      3'd3: f = shifted ? 16'd47872 : 16'd11264;
      3'd4: f = shifted ? 16'd60928 : 16'd14336;
      default: f = 16'd0;
    endcase
    return f;
  endfunction
endpackage

FILE: src/tqg_ram.sv
module tqg_ram #(
  parameter int Width = 32,
  parameter int Depth = 400
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/thermal_q_learning_gear_governor.sv
// Channel   Dir  Width  Contents (low bit first)
// s_axis    in   48     start_episode, temperature, next_temperature, load_level,
//                       explore, explore_gear
// m_axis    out  80     chosen_gear, gear_changed, state_index, next_state_index,
//                       step_reward, updated_value
// cfg       in   3+16   register index, write data
// One tick runs from transfer to the next possible transfer through accept, state
// derivation, two row reads through the single RAM read port, gear decision, reward,
// update, write and the output transfer.
// Arithmetic runs on one shared 34x17 multiplier plus a divide-by-five constant multiply.
// After reset the table is cleared, and no tick is taken until that is done.
// The result sits in the output register; s_axis_tready stays low until it
// has been transferred, so m_axis_tready held low holds off the next tick.
`include "thermal_q_learning_gear_governor_assert.svh"
module thermal_q_learning_gear_governor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // start_episode, temperature, next_temperature,
                                      // load_level, explore, explore_gear, 0 pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // chosen_gear, gear_changed, state_index,
                                      // next_state_index, step_reward, updated_value, pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_STATE, ST_RD_S, ST_RD_NS, ST_REWARD,
    ST_DISC, ST_TD, ST_LR, ST_WRITE, ST_OUT
  } state_t;

  state_t state;
  logic [15:0] learning_rate, discount_factor, hot_limit, warm_limit, cool_limit;
  logic [3:0]  hold_ticks;
  logic [15:0] temp_history [tqg_pkg::HistDepth];
  logic [tqg_pkg::HistW-1:0] history_count;
  logic [2:0]  current_gear;
  logic [3:0]  hold_counter;

  logic [15:0] temp, ntemp;
  logic [8:0]  load;
  logic        explore;
  logic [2:0]  explore_gear;
  logic [tqg_pkg::StateW-1:0] s_idx, ns_idx;
  logic [2:0]  step;
  logic [tqg_pkg::TableAw-1:0] clr_addr;
  logic signed [31:0] best_v, oldv;
  logic [1:0]  best_i;
  logic [2:0]  target, applied_gear;
  logic        shifted;
  logic signed [31:0] reward;
  logic signed [49:0] acc;   // shared accumulator
  logic signed [31:0] nv;

  // RAM
  logic        we;
  logic [tqg_pkg::TableAw-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;

  tqg_ram #(.Width(32), .Depth(tqg_pkg::TableDepth)) u_table (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  // thermal state of a temperature with the history as it is
  function automatic logic [tqg_pkg::StateW-1:0] therm(
      input logic [15:0] t, input logic signed [19:0] tr, input logic use_tr);
    logic signed [19:0] v;
    logic [11:0] r;
    v = $signed({4'd0, t}) + (use_tr ? tr : 20'sd0);
    r = 12'((v + 20'sd128) >>> 8);
    if (v <= 0) return '0;
    if (r > 12'(tqg_pkg::NumStates - 1)) return tqg_pkg::StateW'(tqg_pkg::NumStates - 1);
    return r[tqg_pkg::StateW-1:0];
  endfunction

  // floor(x / 5) by reciprocal multiplication, exact for x below 2**26
  function automatic logic [23:0] div5(input logic [23:0] x);
    logic [49:0] p;
    p = 50'(x) * 50'd13421773;
    return 24'(p >> 26);
  endfunction

  // trend from history
  logic signed [19:0] trend;
  logic [17:0] sum_first, sum_last;
  logic [tqg_pkg::HistW-1:0] hn;
  always_comb begin
    logic signed [19:0] d;
    hn = history_count;
    sum_first = 18'(temp_history[0]) + 18'(temp_history[1]) + 18'(temp_history[2]);
    sum_last = '0;
    for (int k = 3; k < tqg_pkg::HistDepth + 1; k++) begin
      if (hn == tqg_pkg::HistW'(k)) begin
        sum_last = 18'(temp_history[k-3]) + 18'(temp_history[k-2])
                 + 18'(temp_history[k-1]);
      end
    end
    d = 20'($signed({2'b0, sum_last}) - $signed({2'b0, sum_first})) <<< 1;
    if (d < -20'sd256) trend = -20'sd256;
    else if (d > 20'sd512) trend = 20'sd512;
    else trend = d;
  end
  logic use_tr;
  assign use_tr = history_count >= tqg_pkg::HistW'(5);

  // shared multiplier: 34-bit signed by 16-bit unsigned
  logic signed [33:0] mul_a;
  logic [15:0]        mul_b;
  logic signed [50:0] mul_p;
  assign mul_p = mul_a * $signed({1'b0, mul_b});

  function automatic logic signed [33:0] rsh16(input logic signed [50:0] x);
    return 34'((x + 51'sd32768) >>> 16);
  endfunction

  logic [2:0]  tg;
  always_comb begin
    tg = explore_gear;
    if (tg < 3'd1) tg = 3'd1;
    if (tg > 3'd4) tg = 3'd4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      learning_rate <= 16'd6554;
      discount_factor <= 16'd62259;
      hot_limit <= 16'd11520;
      warm_limit <= 16'd11136;
      cool_limit <= 16'd10240;
      hold_ticks <= 4'd10;
      history_count <= '0;
      current_gear <= 3'd4;
      hold_counter <= '0;
      m_axis_tvalid <= 1'b0;
      we <= 1'b0;
    end else begin
      we <= (state == ST_CLEAR) || (state == ST_WRITE);
      if (cfg_valid) begin
        unique case (cfg_index)
          tqg_pkg::RegLearn: learning_rate <= cfg_data;
          tqg_pkg::RegDisc:  discount_factor <= cfg_data;
          tqg_pkg::RegHot:   hot_limit <= cfg_data;
          tqg_pkg::RegWarm:  warm_limit <= cfg_data;
          tqg_pkg::RegCool:  cool_limit <= cfg_data;
          tqg_pkg::RegHold:  hold_ticks <= cfg_data[3:0];
          default: ;
        endcase
      end
      unique case (state)
        ST_CLEAR: begin
          waddr <= clr_addr;
          wdata <= '0;
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == tqg_pkg::TableAw'(tqg_pkg::TableDepth - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            temp <= s_axis_tdata[16:1];
            ntemp <= s_axis_tdata[32:17];
            load <= (s_axis_tdata[41:33] > 9'd256) ? 9'd256 : s_axis_tdata[41:33];
            explore <= s_axis_tdata[42];
            explore_gear <= s_axis_tdata[45:43];
            if (s_axis_tdata[0]) begin
              current_gear <= 3'd4;
              hold_counter <= '0;
            end
            if (s_axis_tdata[0] || history_count < tqg_pkg::HistW'(tqg_pkg::HistDepth)) begin
              temp_history[s_axis_tdata[0] ? '0 : history_count[$clog2(tqg_pkg::HistDepth)-1:0]]
                <= s_axis_tdata[16:1];
              history_count <= s_axis_tdata[0] ? tqg_pkg::HistW'(1) : history_count + 1'b1;
            end else begin
              for (int k = 0; k < tqg_pkg::HistDepth - 1; k++)
                temp_history[k] <= temp_history[k+1];
              temp_history[tqg_pkg::HistDepth-1] <= s_axis_tdata[16:1];
            end
            state <= ST_STATE;
          end
        end
        ST_STATE: begin
          s_idx <= therm(temp, trend, use_tr);
          ns_idx <= therm(ntemp, trend, use_tr);
          raddr <= tqg_pkg::TableAw'(therm(temp, trend, use_tr)) * tqg_pkg::TableAw'(4);
          step <= '0;
          state <= ST_RD_S;
        end
        ST_RD_S: begin
          // row read: address issued each cycle, data back in the next cycle
          step <= (step == 3'd4) ? 3'd0 : step + 1'b1;
          if (step != 3'd4) raddr <= raddr + 1'b1;
          if (step >= 3'd1) begin
            if (step == 3'd1 || $signed(rdata) > best_v) begin
              best_v <= $signed(rdata);
              best_i <= 2'(step - 3'd1);
            end
          end
          if (step == 3'd4) state <= ST_RD_NS;
        end
        ST_RD_NS: begin
          if (step == 3'd0) begin
            target <= explore ? tg : {1'b0, best_i} + 3'd1;
            raddr <= tqg_pkg::TableAw'(ns_idx) * tqg_pkg::TableAw'(4);
            step <= 3'd1;
          end else if (step == 3'd1) begin
            raddr <= tqg_pkg::TableAw'(s_idx) * tqg_pkg::TableAw'(4) + tqg_pkg::TableAw'(target - 3'd1);
            step <= 3'd2;
          end else begin
            // old entry of the target gear, then the four values of the next-state row
            step <= step + 1'b1;
            if (step == 3'd2) begin
              raddr <= tqg_pkg::TableAw'(ns_idx) * tqg_pkg::TableAw'(4);
            end else if (step == 3'd3) begin
              oldv <= $signed(rdata);
              raddr <= raddr + 1'b1;
            end else begin
              if (step <= 3'd6) raddr <= raddr + 1'b1;
              if (step == 3'd4 || $signed(rdata) > best_v) best_v <= $signed(rdata);
              if (step == 3'd7) state <= ST_REWARD;
            end
          end
        end
        ST_REWARD: begin
          if (temp > hot_limit || (target != current_gear && hold_counter == '0)) begin
            applied_gear <= target;
            hold_counter <= hold_ticks;
            shifted <= 1'b1;
          end else begin
            applied_gear <= current_gear;
            if (hold_counter != '0) hold_counter <= hold_counter - 1'b1;
            shifted <= 1'b0;
          end
          state <= ST_DISC;
          step <= '0;
        end
        ST_DISC: begin
          // step0: work factor times load; step1: divide by five after a shift;
          // step2: penalties
          unique case (step)
            3'd0: begin
              acc <= 50'(mul_p);
              step <= 3'd1;
            end
            3'd1: begin
              if (shifted) acc <= 50'(div5(acc[23:0] + 24'd2));
              step <= 3'd2;
            end
            default: begin
              logic signed [31:0] r;
              r = 32'(acc);
              if (ntemp >= hot_limit) r = r - tqg_pkg::PenHot;
              else if (ntemp >= warm_limit) begin
                if (applied_gear == 3'd4) r = r - tqg_pkg::PenWarmT;
                if (applied_gear == 3'd3) r = r - tqg_pkg::PenWarm3;
              end else if (ntemp < cool_limit) begin
                if (applied_gear < 3'd4) r = r - tqg_pkg::PenCool;
              end
              if (load > 9'd204 && applied_gear < 3'd3) r = r - tqg_pkg::PenSlow;
              if (shifted) r = r - tqg_pkg::PenShift;
              reward <= r;
              state <= ST_TD;
            end
          endcase
        end
        ST_TD: begin
          acc <= 50'(rsh16(mul_p)) + 50'(reward) - 50'(oldv);
          state <= ST_LR;
        end
        ST_LR: begin
          logic signed [50:0] t;
          t = 51'(oldv) + 51'(rsh16(mul_p));
          if (t > 51'sd2147483647) nv <= 32'h7fffffff;
          else if (t < -51'sd2147483648) nv <= 32'h80000000;
          else nv <= 32'(t);
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          waddr <= tqg_pkg::TableAw'(s_idx) * tqg_pkg::TableAw'(4) + tqg_pkg::TableAw'(target - 3'd1);
          wdata <= nv;
          current_gear <= applied_gear;
          m_axis_tdata <= {4'd0, nv, 26'(reward), 7'(ns_idx), 7'(s_idx), shifted, applied_gear};
          m_axis_tvalid <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (state)
      ST_TD: begin
        mul_a = 34'(best_v);
        mul_b = discount_factor;
      end
      ST_DISC: begin
        mul_a = 34'(tqg_pkg::gear_work(applied_gear, shifted));
        mul_b = 16'(load);
      end
      default: begin
        mul_a = 34'(acc);
        mul_b = learning_rate;
      end
    endcase
  end

  `TQG_ASSERT_IMP(a_busy_not_ready, clk, rst, state != ST_IDLE, !s_axis_tready, "ready while busy")
  `TQG_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  `TQG_ASSERT_IMP(a_gear_range, clk, rst, m_axis_tvalid, m_axis_tdata[2:0] >= 3'd1 && m_axis_tdata[2:0] <= 3'd4, "gear out of range")
endmodule

FILE: dv/testbench.sv
// Bench for the thermal gear governor.
// - Keeps its own copy of the value table, the temperature history, the gear
//   and the hold-off, and predicts every tick as it is accepted.
// - Every output transfer is checked field by field against the oldest
//   prediction.
// - Both stream sides idle at random, apart from one long stretch with no idling.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // start_episode, temperature, next_temperature,
                                   // load_level, explore, explore_gear, 0 pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;       // chosen_gear, gear_changed, state_index,
                                   // next_state_index, step_reward, updated_value, pad
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  thermal_q_learning_gear_governor DUT (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // One tick as it appears on the output stream, top field first.
  typedef struct packed {
    logic [31:0] value;
    logic [25:0] reward;
    logic [6:0]  nstate_idx;
    logic [6:0]  state;
    logic        changed;
    logic [2:0]  gear;
  } tick_result_t;

  tick_result_t pending_ticks[$];
  int  fail_count;
  int  ticks_sent;
  int  ticks_checked;
  bit  no_idle;   // long stretch with both sides busy
  longint cycle_count;

  // Shadow copy of the governor.
  longint lr_q16, disc_q16, hot_q88, warm_q88, cool_q88, hold_len;
  longint hist[tqg_pkg::HistDepth];
  int     hist_cnt;
  int     cur_gear;
  int     hold_cnt;
  longint q_table[tqg_pkg::TableDepth];

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 30);
  endfunction

  function automatic longint round_q16(longint x);
    return (x + 32768) >>> 16;
  endfunction

  // State from temperature plus the clamped trend over the history.
  function automatic int thermal_index(longint t);
    longint v, first, last, trend;
    int n;
    v = t;
    if (hist_cnt >= 5) begin
      n = hist_cnt;
      first = hist[0] + hist[1] + hist[2];
      last  = hist[n-3] + hist[n-2] + hist[n-1];
      trend = 2 * (last - first);
      if (trend < -256) trend = -256;
      if (trend > 512) trend = 512;
      v += trend;
    end
    if (v <= 0) return 0;
    v = (v + 128) >>> 8;
    if (v > tqg_pkg::NumStates - 1) v = tqg_pkg::NumStates - 1;
    return int'(v);
  endfunction

  // Best gear index 0..3 of a row; ties go to the lowest gear.
  function automatic int best_gear(int s);
    int b;
    b = 0;
    for (int i = 1; i < 4; i++)
      if (q_table[s*4+i] > q_table[s*4+b]) b = i;
    return b;
  endfunction

  function automatic tick_result_t predict_tick(logic [47:0] d);
    tick_result_t r;
    longint temp, ntemp, load, freq, rew, oldv, nmax, td, nv;
    int s, ns, target, gear_now;
    bit shifted;
    temp  = d[16:1];
    ntemp = d[32:17];
    load  = d[41:33];
    if (load > 256) load = 256;
    if (d[0]) begin
      hist_cnt = 0;
      cur_gear = 4;
      hold_cnt = 0;
    end
    if (hist_cnt < tqg_pkg::HistDepth) begin
      hist[hist_cnt] = temp;
      hist_cnt++;
    end else begin
      for (int i = 0; i < tqg_pkg::HistDepth - 1; i++) hist[i] = hist[i+1];
      hist[tqg_pkg::HistDepth-1] = temp;
    end
    s = thermal_index(temp);
    if (d[42]) begin
      target = d[45:43];
      if (target < 1) target = 1;
      if (target > 4) target = 4;
    end else begin
      target = best_gear(s) + 1;
    end
    // Overheat forces the target; otherwise only once the hold-off has run out.
    if (temp > hot_q88 || (target != cur_gear && hold_cnt == 0)) begin
      gear_now = target;
      hold_cnt = int'(hold_len);
      shifted = 1'b1;
    end else begin
      gear_now = cur_gear;
      if (hold_cnt > 0) hold_cnt--;
      shifted = 1'b0;
    end
    case (gear_now)
      1: freq = 800;
      2: freq = 1500;
      3: freq = 2200;
      default: freq = 2800;
    endcase
    if (shifted) rew = (freq * load * 544 + 62) / 125;
    else rew = (freq * load * 128 + 12) / 25;
    if (ntemp >= hot_q88) begin
      rew -= tqg_pkg::PenHot;
    end else if (ntemp >= warm_q88) begin
      if (gear_now == 4) rew -= tqg_pkg::PenWarmT;
      if (gear_now == 3) rew -= tqg_pkg::PenWarm3;
    end else if (ntemp < cool_q88) begin
      if (gear_now < 4) rew -= tqg_pkg::PenCool;
    end
    if (load * 5 > 1024 && freq < 2000) rew -= tqg_pkg::PenSlow;
    if (shifted) rew -= tqg_pkg::PenShift;
    ns   = thermal_index(ntemp);
    oldv = q_table[s*4 + target - 1];
    nmax = q_table[ns*4 + best_gear(ns)];
    td   = rew + round_q16(disc_q16 * nmax) - oldv;
    nv   = oldv + round_q16(lr_q16 * td);
    if (nv > 64'sd2147483647) nv = 64'sd2147483647;
    if (nv < -64'sd2147483648) nv = -64'sd2147483648;
    q_table[s*4 + target - 1] = nv;
    cur_gear = gear_now;
    r.gear       = 3'(gear_now);
    r.changed    = shifted;
    r.state      = 7'(s);
    r.nstate_idx = 7'(ns);
    r.reward     = 26'(rew);
    r.value      = 32'(nv);
    return r;
  endfunction

  // Sends one tick; called and returns just after a rising edge.
  task automatic send_tick(bit start, int temp, int ntemp, int load, bit expl, int eg);
    logic [47:0] d;
    d = {2'b00, 3'(eg), expl, 9'(load), 16'(ntemp), 16'(temp), start};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
    pending_ticks.push_back(predict_tick(d));
    ticks_sent++;
    if (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    s_axis_tvalid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      tqg_pkg::RegLearn: lr_q16   = val & 16'hFFFF;
      tqg_pkg::RegDisc:  disc_q16 = val & 16'hFFFF;
      tqg_pkg::RegHot:   hot_q88  = val & 16'hFFFF;
      tqg_pkg::RegWarm:  warm_q88 = val & 16'hFFFF;
      tqg_pkg::RegCool:  cool_q88 = val & 16'hFFFF;
      tqg_pkg::RegHold:  hold_len = val & 4'hF;
      default: ;
    endcase
  endtask

  task automatic set_all(int lr, int dc, int hot, int warm, int cool, int hold);
    write_reg(tqg_pkg::RegLearn, lr);
    write_reg(tqg_pkg::RegDisc, dc);
    write_reg(tqg_pkg::RegHot, hot);
    write_reg(tqg_pkg::RegWarm, warm);
    write_reg(tqg_pkg::RegCool, cool);
    write_reg(tqg_pkg::RegHold, hold);
  endtask

  // Field extremes, every gear override and the out-of-range inputs.
  task automatic test_directed();
    send_tick(1, 16'h0000, 16'h0000, 0, 0, 1);
    send_tick(0, 16'hFFFF, 16'hFFFF, 256, 0, 1);   // overheat, next overheat
    send_tick(0, 16'h0000, 16'hFFFF, 511, 1, 0);   // load clipped, gear 0 -> 1
    send_tick(0, 10000, 11200, 257, 1, 7);         // gear 7 -> 4, warm
    send_tick(0, 10000, 9000, 230, 1, 5);          // cool band
    for (int g = 1; g <= 4; g++) send_tick(0, 11600, 11300, 255, 1, g);  // forced
    send_tick(1, 10500, 10600, 128, 1, 2);          // hold-off blocks after start
    send_tick(0, 10500, 10600, 128, 1, 3);
    send_tick(0, 10500, 10600, 128, 1, 1);
    for (int i = 0; i < 6; i++)                     // rising temperatures, trend clamped low
      send_tick(0, 8000 + i*600, 8000 + i*700, 205, 0, 6);
    for (int i = 0; i < 5; i++)                     // falling temperatures, trend clamped high
      send_tick(0, 12000 - i*500, 11000, 206, 0, 2);
    send_tick(0, 25400, 25600, 100, 0, 4);          // near the top state
  endtask

  // Episodes of drifting temperatures with random content, plus some noise.
  task automatic run_episodes(int n_items);
    int done, len, temp, ntemp;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_tick($urandom_range(1), $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(511), $urandom_range(1), $urandom_range(7));
        done++;
      end else begin
        len  = $urandom_range(3, 25);
        temp = $urandom_range(7000, 12500);
        for (int i = 0; i < len && done < n_items; i++) begin
          ntemp = temp + $urandom_range(0, 400) - 200;
          if (ntemp < 0) ntemp = 0;
          send_tick(i == 0, temp, ntemp,
                    ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(256),
                    $urandom_range(4) == 0,
                    ($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(1, 4));
          temp = ntemp;
          done++;
        end
      end
    end
  endtask

  task automatic test_settings();
    set_all(65535, 65535, 65535, 65535, 0, 0);      // upper extremes, no hold-off
    run_episodes(50);
    set_all(0, 0, 0, 0, 65535, 15);                 // lower extremes, longest hold
    run_episodes(50);
    set_all($urandom_range(65535), $urandom_range(65535), $urandom_range(9000, 13000),
            $urandom_range(9000, 13000), $urandom_range(8000, 12000), $urandom_range(15));
    run_episodes(80);
  endtask

  task automatic test_random();
    set_all(6554, 62259, 11520, 11136, 10240, 10);
    run_episodes(150);
    no_idle = 1'b1;
    run_episodes(80);
    no_idle = 1'b0;
    set_all(30000, 50000, 11520, 11136, 10240, 3);
    run_episodes(100);
  endtask

  // Output side: random back-pressure and the field checks.
  always @(posedge clk) begin
    tick_result_t got, want;
    m_axis_tready <= !idle_now();
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[75:0];
      if (pending_ticks.size() == 0) begin
        $error("unexpected output transfer %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_ticks.pop_front();
        ticks_checked++;
        if (got.gear != want.gear) begin
          $error("chosen_gear: expected %0d, got %0d", want.gear, got.gear);
          fail_count++;
        end
        if (got.changed != want.changed) begin
          $error("gear_changed: expected %0d, got %0d", want.changed, got.changed);
          fail_count++;
        end
        if (got.state != want.state) begin
          $error("state_index: expected %0d, got %0d", want.state, got.state);
          fail_count++;
        end
        if (got.nstate_idx != want.nstate_idx) begin
          $error("next_state_index: expected %0d, got %0d",
                 want.nstate_idx, got.nstate_idx);
          fail_count++;
        end
        if (got.reward != want.reward) begin
          $error("step_reward: expected %0d, got %0d",
                 $signed(want.reward), $signed(got.reward));
          fail_count++;
        end
        if (got.value != want.value) begin
          $error("updated_value: expected %0d, got %0d",
                 $signed(want.value), $signed(got.value));
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    fail_count = 0;
    ticks_sent = 0;
    ticks_checked = 0;
    no_idle = 1'b0;
    lr_q16 = 6554;
    disc_q16 = 62259;
    hot_q88 = 11520;
    warm_q88 = 11136;
    cool_q88 = 10240;
    hold_len = 10;
    hist_cnt = 0;
    cur_gear = 4;
    hold_cnt = 0;
    foreach (hist[i]) hist[i] = 0;
    foreach (q_table[i]) q_table[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_settings();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("%0d of %0d ticks checked over %0d register settings, directed corners and",
             ticks_checked, ticks_sent, 6);
    $display("random episodes with overheat, hold-off and exploration cases");
    if (fail_count == 0 && pending_ticks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
